// File: rtl/ffa_pkg.sv
package ffa_pkg;

   localparam int MAX_BLOCKS   = 256;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 8;
   localparam int LEN_W        = 17;
   localparam int ADDR_W       = 16;
   localparam int BYTES_W      = 16;
   localparam int STATUS_W     = 2;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 24;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NOSPACE  = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_END,
      S_RESP
   } state_type;

   // one block table entry
   typedef struct packed {
      logic             is_free;
      logic [LEN_W-1:0] length;
   } entry_type;

   // block table access: one write port, one read port
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } tbl_ctrl_type;

endpackage

// File: rtl/ffa_table.sv
module ffa_table (
   input  logic                 clock,
   input  ffa_pkg::tbl_ctrl_type ctrl,
   output ffa_pkg::entry_type    rd_data
);
   import ffa_pkg::*;

   entry_type mem [MAX_BLOCKS];
   entry_type rd_data_ff;

   // contents undefined until written; only entries below the block count are read
   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem[ctrl.waddr] <= ctrl.wdata;
      end
      rd_data_ff <= mem[ctrl.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/first_fit_block_allocator.sv
// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid / req_tready  tdata {free_address, req_bytes}, tuser req_type
// rsp_      out        rsp_tvalid / rsp_tready  tdata {status, user_address}
// csr_      in         csr_we                   csr_wdata = heap_limit
//
// One request at a time; the walk reads one table entry per cycle from a synchronous RAM.
// The walk stops at the first matching block, or runs past all blocks into END; either way
// the result goes through RESP into the output register.
// Reset clears block count, heap top and handshake state and sets the limit to the full
// heap; the table RAM is not cleared, entries at or above the count are never read.
// A stalled result waits in the output register; the next walk may run, then holds in RESP.
module first_fit_block_allocator (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata[15:0] req_bytes, tdata[31:16] free_address
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ffa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request: tuser[0] req_type (0 allocate, 1 free)
   input  logic                             req_tuser,
   // response: tdata[15:0] user_address, tdata[17:16] status, rest zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ffa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // heap limit register
   input  logic                             csr_we,
   input  logic [ffa_pkg::LEN_W-1:0]        csr_wdata
);
   import ffa_pkg::*;

   localparam logic [LEN_W-1:0]  HDR_LEN   = LEN_W'(HEADER_BYTES);
   localparam logic [LEN_W:0]    HDR_WIDE  = (LEN_W+1)'(HEADER_BYTES);
   localparam logic [LEN_W-1:0]  HEAP_LIM  = LEN_W'(HEAP_BYTES);
   localparam logic [LEN_W:0]    ADDR_MAX  = (LEN_W+1)'((1 << ADDR_W) - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_BLOCKS);

   state_type          state_ff, state_in;
   req_kind_type       kind_ff, kind_in;
   logic [LEN_W-1:0]   need_ff, need_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [LEN_W-1:0]   start_ff, start_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   top_ff, top_in;
   logic [LEN_W-1:0]   limit_ff, limit_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   tbl_ctrl_type       tbl_ctrl;
   entry_type          entry;

   logic               req_fire;
   logic               alloc_hit;
   logic               free_hit;
   logic               last_entry;
   logic [LEN_W-1:0]   limit_eff;
   logic [LEN_W:0]     top_end;
   logic [LEN_W:0]     top_user;
   logic               append_ok;

   ffa_table u_table (
      .clock   (clock),
      .ctrl    (tbl_ctrl),
      .rd_data (entry)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // entry under inspection is k_ff, starting at byte start_ff
   assign alloc_hit  = entry.is_free && (entry.length >= need_ff);
   assign free_hit   = (({1'b0, start_ff} + HDR_WIDE) == {{(LEN_W+1-ADDR_W){1'b0}}, addr_ff});
   assign last_entry = (({1'b0, k_ff} + CNT_W'(1)) == count_ff);

   // append checks: table room, limit (capped at heap size), 16-bit user address
   assign limit_eff  = (limit_ff > HEAP_LIM) ? HEAP_LIM : limit_ff;
   assign top_end    = {1'b0, top_ff} + {1'b0, need_ff};
   assign top_user   = {1'b0, top_ff} + HDR_WIDE;
   assign append_ok  = (count_ff < CNT_FULL) && (top_end <= {1'b0, limit_eff})
                       && (top_user <= ADDR_MAX);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      need_in       = need_ff;
      addr_in       = addr_ff;
      k_in          = k_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      limit_in      = csr_we ? csr_wdata : limit_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      tbl_ctrl.we    = 1'b0;
      tbl_ctrl.waddr = k_ff;
      tbl_ctrl.wdata = entry;

      case (state_ff)
         S_IDLE: begin
            k_in     = '0;
            start_in = '0;
            if (req_fire) begin
               kind_in  = req_kind_type'(req_tuser);
               need_in  = {1'b0, req_tdata[BYTES_W-1:0]} + HDR_LEN;
               addr_in  = req_tdata[BYTES_W +: ADDR_W];
               state_in = (count_ff == '0) ? S_END : S_WALK;
            end
         end
         S_WALK: begin
            if (kind_ff == REQ_ALLOC && alloc_hit) begin
               tbl_ctrl.we           = 1'b1;
               tbl_ctrl.wdata.is_free = 1'b0;
               res_addr_in   = ADDR_W'({1'b0, start_ff} + HDR_WIDE);
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end else if (kind_ff == REQ_FREE && free_hit) begin
               tbl_ctrl.we           = 1'b1;
               tbl_ctrl.wdata.is_free = 1'b1;
               res_addr_in   = '0;
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end else begin
               start_in = start_ff + entry.length;
               if (last_entry) begin
                  state_in = S_END;
               end else begin
                  k_in = k_ff + IDX_W'(1);
               end
            end
         end
         S_END: begin
            state_in = S_RESP;
            if (kind_ff == REQ_FREE) begin
               res_addr_in   = '0;
               res_status_in = ST_NOTFOUND;
            end else if (append_ok) begin
               tbl_ctrl.we            = 1'b1;
               tbl_ctrl.waddr         = count_ff[IDX_W-1:0];
               tbl_ctrl.wdata.is_free = 1'b0;
               tbl_ctrl.wdata.length  = need_ff;
               count_in      = count_ff + CNT_W'(1);
               top_in        = top_end[LEN_W-1:0];
               res_addr_in   = top_user[ADDR_W-1:0];
               res_status_in = ST_OK;
            end else begin
               res_addr_in   = '0;
               res_status_in = ST_NOSPACE;
            end
         end
         S_RESP: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-ADDR_W-STATUS_W){1'b0}},
                               res_status_ff, res_addr_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // read the entry the walk looks at next cycle
      tbl_ctrl.raddr = k_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         limit_ff     <= HEAP_LIM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      k_ff          <= k_in;
      start_ff      <= start_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// File: verif/ffa_heap_checker.sv
`timescale 1ns / 100ps

module ffa_heap_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ffa_pkg::REQ_DATA_W-1:0] req_tdata,   // [15:0] req_bytes, [31:16] free_address
   input  logic                           req_tuser,   // [0] req_type
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ffa_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [15:0] user_address, [17:16] status
   input  logic                           csr_we,
   input  logic [ffa_pkg::LEN_W-1:0]      csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import ffa_pkg::*;

   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] user_address;
   } heap_answer_type;

   // shadow block table
   logic [LEN_W-1:0] blk_len [MAX_BLOCKS];
   bit               blk_free [MAX_BLOCKS];
   int unsigned      blk_cnt;
   int unsigned      heap_end;
   int unsigned      heap_limit;

   heap_answer_type  answers_q [$];
   heap_answer_type  want;
   status_type       got_status;
   logic [ADDR_W-1:0] got_address;
   int               mismatches = 0;
   int               outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   function automatic heap_answer_type place_or_release(req_kind_type kind,
                                                        logic [BYTES_W-1:0] bytes,
                                                        logic [ADDR_W-1:0] addr);
      heap_answer_type ans;
      int unsigned     start;
      int unsigned     need;
      int unsigned     room;
      ans.status       = ST_OK;
      ans.user_address = '0;
      start            = 0;
      if (kind == REQ_FREE) begin
         for (int k = 0; k < blk_cnt; k++) begin
            if (start + HEADER_BYTES == addr) begin
               blk_free[k] = 1'b1;
               return ans;
            end
            start += blk_len[k];
         end
         ans.status = ST_NOTFOUND;
         return ans;
      end
      need = bytes + HEADER_BYTES;
      // first fit over existing blocks
      for (int k = 0; k < blk_cnt; k++) begin
         if (blk_free[k] && blk_len[k] >= need) begin
            blk_free[k]      = 1'b0;
            ans.user_address = ADDR_W'(start + HEADER_BYTES);
            return ans;
         end
         start += blk_len[k];
      end
      // append at the end of the heap
      room = (heap_limit < HEAP_BYTES) ? heap_limit : HEAP_BYTES;
      if (blk_cnt >= MAX_BLOCKS || heap_end + need > room ||
          heap_end + HEADER_BYTES > 16'hFFFF) begin
         ans.status = ST_NOSPACE;
         return ans;
      end
      blk_len[blk_cnt]  = LEN_W'(need);
      blk_free[blk_cnt] = 1'b0;
      blk_cnt++;
      ans.user_address = ADDR_W'(heap_end + HEADER_BYTES);
      heap_end += need;
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         blk_cnt    = 0;
         heap_end   = 0;
         heap_limit = HEAP_BYTES;
         answers_q.delete();
      end else begin
         if (csr_we)
            heap_limit = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got_status  = status_type'(rsp_tdata[ADDR_W +: STATUS_W]);
            got_address = rsp_tdata[ADDR_W-1:0];
            if (answers_q.size() == 0) begin
               $error("unexpected response: user_address %0d, status %0d",
                      got_address, got_status);
               mismatches++;
            end else begin
               want = answers_q.pop_front();
               if (got_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got_status);
                  mismatches++;
               end
               if (got_address !== want.user_address) begin
                  $error("user_address: expected %0d, actual %0d",
                         want.user_address, got_address);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            answers_q.push_back(place_or_release(req_kind_type'(req_tuser),
                                                 req_tdata[BYTES_W-1:0],
                                                 req_tdata[BYTES_W +: ADDR_W]));
      end
      outstanding = answers_q.size();
   end

endmodule

// File: verif/tb_first_fit_block_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
   import ffa_pkg::*;

   // generous bound: ~1500 transactions, each a full table walk plus stalls, many times over
   localparam int unsigned CYCLE_LIMIT = 2_500_000;
   localparam int          PHASES      = 6;
   localparam int          PHASE_ITEMS = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [15:0] req_bytes, [31:16] free_address
   logic                  req_tuser;   // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [15:0] user_address, [17:16] status
   logic                  csr_we;
   logic [LEN_W-1:0]      csr_wdata;

   int                    fail_count;
   int                    pending;

   // no random idling on either side while set
   bit                    steady = 1'b0;
   int unsigned           cycles = 0;

   // stimulus-side view of the heap, rebuilt from responses; steers the frees and the
   // final fill, never used for checking
   int                    sent_sizes [$];      // -1 marks a free transaction
   logic [ADDR_W-1:0]     live_addrs [$];
   int                    tb_heap_end = 0;
   int                    tb_blocks = 0;
   status_type            last_status = ST_OK;
   int                    snoop_size;
   logic [ADDR_W-1:0]     snoop_addr;
   status_type            snoop_status;

   first_fit_block_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   ffa_heap_checker heap_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("first_fit_block_allocator verification failed");
         $finish;
      end
   end

   // response side stalls about 29 times in 100, except while steady is set
   always @(negedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 29);

   // track heap end, block count and live addresses from completed transactions
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sent_sizes.push_back(req_tuser == REQ_FREE ? -1 : int'(req_tdata[BYTES_W-1:0]));
         if (rsp_tvalid && rsp_tready && sent_sizes.size() != 0) begin
            snoop_size   = sent_sizes.pop_front();
            snoop_addr   = rsp_tdata[ADDR_W-1:0];
            snoop_status = status_type'(rsp_tdata[ADDR_W +: STATUS_W]);
            last_status  = snoop_status;
            if (snoop_size >= 0 && snoop_status == ST_OK) begin
               // an append starts exactly at the old heap end; reuse starts below it
               if (int'(snoop_addr) - HEADER_BYTES == tb_heap_end) begin
                  tb_heap_end = int'(snoop_addr) + snoop_size;
                  tb_blocks++;
               end
               live_addrs.push_back(snoop_addr);
               if (live_addrs.size() > 400)
                  void'(live_addrs.pop_front());
            end
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance with valid
   // still high, so back-to-back transactions keep it up
   task automatic send_req(req_kind_type kind, logic [BYTES_W-1:0] bytes,
                           logic [ADDR_W-1:0] addr);
      while (!steady && $urandom_range(99) < 29) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {addr, bytes};
      req_tuser  = kind;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_tvalid = 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   // limit changes only with the block idle
   task automatic write_heap_limit(logic [LEN_W-1:0] value);
      hold_until_drained();
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // mostly small payloads so the table fills before the heap does
   function automatic logic [BYTES_W-1:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return BYTES_W'($urandom_range(63));
      else if (r < 90)
         return BYTES_W'($urandom_range(1023, 64));
      else if (r < 99)
         return BYTES_W'($urandom_range(8191, 1024));
      return BYTES_W'($urandom_range(16'hFFFF));
   endfunction

   task automatic send_random_item();
      int                r;
      int                idx;
      logic [ADDR_W-1:0] addr;
      r    = $urandom_range(99);
      addr = ADDR_W'($urandom_range(16'hFFFF));
      if (r < 50) begin
         send_req(REQ_ALLOC, pick_size(), addr);
      end else if (r < 93 && live_addrs.size() != 0) begin
         idx  = $urandom_range(live_addrs.size() - 1);
         addr = live_addrs[idx];
         if (r < 85) begin
            // well-formed free; some addresses stay in the pool for double frees
            if ($urandom_range(4) != 0)
               live_addrs.delete(idx);
         end else begin
            // near miss, lands inside a block or off the end
            addr = ($urandom_range(1)) ? addr + ADDR_W'($urandom_range(7, 1))
                                       : addr - ADDR_W'($urandom_range(7, 1));
         end
         send_req(REQ_FREE, BYTES_W'($urandom_range(16'hFFFF)), addr);
      end else begin
         send_req(REQ_FREE, BYTES_W'($urandom_range(16'hFFFF)), addr);
      end
   endtask

   initial begin
      logic [LEN_W-1:0] limit_val;
      int               tries;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_ALLOC;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      reset      = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed ----
      send_req(REQ_ALLOC, 16'd0, 16'd0);        // block 0, len 8, addr 8
      send_req(REQ_ALLOC, 16'd1, 16'd0);        // block 1, len 9, addr 16
      send_req(REQ_FREE,  16'd0, 16'd8);
      send_req(REQ_FREE,  16'd0, 16'd8);        // double free still ok
      send_req(REQ_FREE,  16'd0, 16'd0);        // unknown address
      send_req(REQ_FREE,  16'd0, 16'hFFFF);     // unknown address, all ones
      send_req(REQ_FREE,  16'd0, 16'd12);       // points inside block 1
      send_req(REQ_ALLOC, 16'd0, 16'd0);        // reuses block 0
      send_req(REQ_FREE,  16'd0, 16'd16);
      send_req(REQ_ALLOC, 16'd1, 16'd0);        // exact fit into block 1
      send_req(REQ_FREE,  16'd0, 16'd16);
      send_req(REQ_ALLOC, 16'd2, 16'd0);        // block 1 too short, appends at 17
      send_req(REQ_ALLOC, 16'hFFFF, 16'd0);     // heap exhausted

      // limit below heap end: reuse still works, appends fail
      write_heap_limit(17'd0);
      send_req(REQ_ALLOC, 16'd0, 16'd0);        // reuses free block 1
      send_req(REQ_ALLOC, 16'd0, 16'd0);        // nothing free, append blocked
      send_req(REQ_FREE,  16'd0, 16'd8);
      send_req(REQ_ALLOC, 16'd3, 16'd0);        // block 0 too short, append blocked
      send_req(REQ_ALLOC, 16'd0, 16'd0);        // reuses block 0

      // limit above the heap size is clamped to it
      write_heap_limit(17'h1FFFF);
      send_req(REQ_ALLOC, 16'd100, 16'd0);

      write_heap_limit(17'd64);
      send_req(REQ_ALLOC, 16'd0, 16'd0);
      send_req(REQ_FREE,  16'd0, 16'd25);
      send_req(REQ_ALLOC, 16'd1, 16'd0);        // reuses block 2 under the low limit

      write_heap_limit(17'd65536);

      // ---- random phases, each with its own heap limit ----
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(4))
            0: limit_val = 17'd65536;
            1: limit_val = 17'h1FFFF;
            2: limit_val = LEN_W'($urandom_range(17'h1FFFF));
            3: limit_val = LEN_W'(tb_heap_end / 2);           // below heap end
            default: limit_val = LEN_W'(tb_heap_end + $urandom_range(4096));
         endcase
         if (p == 0)
            limit_val = 17'd65536;
         write_heap_limit(limit_val);
         steady = (p == 3);
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_item();
      end
      steady = 1'b0;

      // ---- final fill: either the table runs out or the address width does ----
      write_heap_limit(17'd65536);
      if ($urandom_range(1) && tb_heap_end <= 65520 && tb_blocks < MAX_BLOCKS - 1) begin
         // one block ending at 65528: the next append would need user address 65536
         send_req(REQ_ALLOC, BYTES_W'(65520 - tb_heap_end), 16'd0);
         hold_until_drained();
      end
      // soak up every free block with zero-byte allocations until one is refused
      tries = 0;
      do begin
         send_req(REQ_ALLOC, 16'd0, ADDR_W'($urandom_range(16'hFFFF)));
         hold_until_drained();
         tries++;
      end while (last_status == ST_OK && tries < 300);
      // once more with everything in use
      send_req(REQ_ALLOC, 16'd0, 16'd0);
      send_req(REQ_FREE, 16'hFFFF, 16'd8);

      hold_until_drained();
      repeat (300) @(negedge clock);
      if (fail_count == 0)
         $display("first_fit_block_allocator verification clean");
      else
         $display("first_fit_block_allocator verification failed");
      $finish;
   end

endmodule
